@@ design/htfr_pkg.sv @@
// Package for the header/trailer frame receiver: register indexes, reset
// values, configuration and result record types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package htfr_pkg;

  localparam int unsigned DefaultFrameLen = 8;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned StoreIndexW     = 3;
  localparam int unsigned TotalW          = 16;
  localparam int unsigned CfgIndexW       = 3;

  typedef enum logic [CfgIndexW-1:0] {
    REG_SYNC_FIRST     = 3'd0,
    REG_SYNC_SECOND    = 3'd1,
    REG_END_FIRST      = 3'd2,
    REG_END_SECOND     = 3'd3,
    REG_LINK_THRESHOLD = 3'd4
  } reg_index_t;

  localparam logic [ByteW-1:0] SyncFirstReset     = 8'hff;
  localparam logic [ByteW-1:0] SyncSecondReset    = 8'hfe;
  localparam logic [ByteW-1:0] EndFirstReset      = 8'h66;
  localparam logic [ByteW-1:0] EndSecondReset     = 8'h65;
  localparam logic [ByteW-1:0] LinkThresholdReset = 8'd10;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
    logic [ByteW-1:0] end_first;
    logic [ByteW-1:0] end_second;
    logic [ByteW-1:0] link_threshold;
  } cfg_t;

  typedef struct packed {
    logic                   store_valid;
    logic [StoreIndexW-1:0] store_index;
    logic [ByteW-1:0]       store_byte;
    logic                   frame_done;
    logic                   frame_rejected;
    logic [TotalW-1:0]      frame_total;
    logic                   link_enabled;
    logic                   collecting;
  } result_t;

endpackage

`default_nettype wire

@@ design/header_trailer_frame_receiver_unit.sv @@
// Header/trailer frame receiver: top level with configuration registers,
// the frame tracking core and the result register.
// Depends on htfr_pkg and htfr_core.
//
// Usage:
//   in_valid/in_ready carry one received byte (rx_byte) per request.
//   out_valid/out_ready carry one result per input byte: store flag, index
//   and byte, frame done/rejected pulses, accepted-frame total, link flag
//   and the collecting status.
//   cfg_valid/cfg_ready write register cfg_index with cfg_data; cfg_ready is
//   always high. Indexes beyond the register list are ignored. Write only
//   while no result is outstanding.
// Timing: a result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while results are taken. The result register is the only stage;
//   in_ready is high whenever it is empty or being drained this cycle.
// Stall: if out_ready stays low, the held result waits and in_ready drops
//   until it is taken.
// Reset: rst clears the byte history, frame state, link and frame counters,
//   drops out_valid and restores the register defaults (sync FF FE,
//   trailer 66 65, link threshold 10).
`timescale 1ns / 1ps
`default_nettype none

module header_trailer_frame_receiver_unit #(
  parameter int unsigned FRAME_LEN = htfr_pkg::DefaultFrameLen
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [htfr_pkg::ByteW-1:0]    rx_byte,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic                          store_valid,
  output      logic [htfr_pkg::StoreIndexW-1:0] store_index,
  output      logic [htfr_pkg::ByteW-1:0]    store_byte,
  output      logic                          frame_done,
  output      logic                          frame_rejected,
  output      logic [htfr_pkg::TotalW-1:0]   frame_total,
  output      logic                          link_enabled,
  output      logic                          collecting,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [htfr_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [htfr_pkg::ByteW-1:0]    cfg_data
);
  import htfr_pkg::*;

  cfg_t    cfg;
  result_t core_result;
  result_t out_reg;
  logic    in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first     <= SyncFirstReset;
      cfg.sync_second    <= SyncSecondReset;
      cfg.end_first      <= EndFirstReset;
      cfg.end_second     <= EndSecondReset;
      cfg.link_threshold <= LinkThresholdReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:     cfg.sync_first     <= cfg_data;
        REG_SYNC_SECOND:    cfg.sync_second    <= cfg_data;
        REG_END_FIRST:      cfg.end_first      <= cfg_data;
        REG_END_SECOND:     cfg.end_second     <= cfg_data;
        REG_LINK_THRESHOLD: cfg.link_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  htfr_core #(
    .FRAME_LEN(FRAME_LEN)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (in_accept),
    .rx_byte (rx_byte),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_reg <= core_result;
    end
  end

  assign store_valid    = out_reg.store_valid;
  assign store_index    = out_reg.store_index;
  assign store_byte     = out_reg.store_byte;
  assign frame_done     = out_reg.frame_done;
  assign frame_rejected = out_reg.frame_rejected;
  assign frame_total    = out_reg.frame_total;
  assign link_enabled   = out_reg.link_enabled;
  assign collecting     = out_reg.collecting;

  // a frame ends either accepted or rejected, never both
  a_done_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_done && frame_rejected))
    else $error("frame done and rejected together");

  // frame end only on a stored byte, and gathering stops there
  a_end_on_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_done || frame_rejected) |-> store_valid && !collecting)
    else $error("frame end without store or while still collecting");

  // link flag is sticky across results
  a_link_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && link_enabled |=> !out_valid || link_enabled)
    else $error("link flag cleared");

  // gathering status implies the byte was stored
  a_collect_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && collecting |-> store_valid)
    else $error("collecting without store");

endmodule

`default_nettype wire

@@ design/htfr_core.sv @@
// Frame tracking core: byte history, sync hunt, frame position, trailer check,
// link counter and accepted-frame counter. Result is combinational per request.
// Depends on htfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htfr_core #(
  parameter int unsigned FRAME_LEN = htfr_pkg::DefaultFrameLen
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire htfr_pkg::cfg_t          cfg,
  input  wire logic                    step,
  input  wire logic [htfr_pkg::ByteW-1:0] rx_byte,
  output htfr_pkg::result_t            result
);
  import htfr_pkg::*;

  localparam int unsigned IdxW = $clog2(FRAME_LEN + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_LEN);

  logic [ByteW-1:0]  prev_byte, prev_prev_byte;
  logic [IdxW-1:0]   frame_index, frame_index_next;
  logic              in_frame, in_frame_next;
  logic              resync, resync_next;
  logic [ByteW-1:0]  link_count, link_count_next;
  logic              link_flag, link_flag_next;
  logic [TotalW-1:0] frame_counter, frame_counter_next;

  logic              sync_hit;
  logic              storing;
  logic [IdxW-1:0]   idx_inc;
  logic [IdxW+2:0]   idx_ext;

  always_comb begin
    link_count_next = link_count;
    link_flag_next  = link_flag;
    if (!link_flag) begin
      link_count_next = link_count + 8'd1;
      if (link_count_next > cfg.link_threshold) begin
        link_flag_next = 1'b1;
      end
    end
  end

  assign sync_hit = (!in_frame || resync) &&
                    (prev_byte == cfg.sync_second) && (prev_prev_byte == cfg.sync_first);

  always_comb begin
    in_frame_next      = in_frame;
    resync_next        = resync;
    frame_index_next   = frame_index;
    frame_counter_next = frame_counter;
    result             = '0;

    if (sync_hit) begin
      in_frame_next    = 1'b1;
      resync_next      = 1'b0;
      frame_index_next = '0;
    end

    storing = in_frame_next && !resync_next;
    idx_inc = frame_index_next + IdxW'(1);
    idx_ext = (IdxW + 3)'(frame_index_next);

    if (storing) begin
      result.store_valid = 1'b1;
      result.store_index = idx_ext[StoreIndexW-1:0];
      result.store_byte  = rx_byte;
      frame_index_next   = idx_inc;
      if (idx_inc >= LastIdx) begin
        frame_index_next = LastIdx;
        // trailer: last byte now, next-to-last in history
        if (rx_byte == cfg.end_second && prev_byte == cfg.end_first) begin
          frame_counter_next = frame_counter + TotalW'(1);
          in_frame_next      = 1'b0;
          result.frame_done  = 1'b1;
        end else begin
          resync_next           = 1'b1;
          result.frame_rejected = 1'b1;
        end
      end
    end

    result.frame_total  = frame_counter_next;
    result.link_enabled = link_flag_next;
    result.collecting   = in_frame_next && !resync_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte      <= '0;
      prev_prev_byte <= '0;
      frame_index    <= '0;
      in_frame       <= 1'b0;
      resync         <= 1'b0;
      link_count     <= '0;
      link_flag      <= 1'b0;
      frame_counter  <= '0;
    end else if (step) begin
      prev_byte      <= rx_byte;
      prev_prev_byte <= prev_byte;
      frame_index    <= frame_index_next;
      in_frame       <= in_frame_next;
      resync         <= resync_next;
      link_count     <= link_count_next;
      link_flag      <= link_flag_next;
      frame_counter  <= frame_counter_next;
    end
  end

endmodule

`default_nettype wire

@@ tb/header_trailer_frame_receiver_unit_tb.sv @@
// Self-checking bench for header_trailer_frame_receiver_unit: directed byte table,
// then framed random traffic under several register settings and idle/stall mixes.
// Depends on htfr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module header_trailer_frame_receiver_unit_tb;
  import htfr_pkg::*;

  localparam int unsigned FrameLen = DefaultFrameLen;
  localparam int unsigned DirRows = 24;
  localparam int unsigned PhaseBytes = 200;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [CfgIndexW-1:0] RegUnused = 3'd7;
  localparam logic [32:0] Untyped = '0;

  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic             given;
    result_t          res;
  } dir_row_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ByteW-1:0]       rx_byte = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   store_valid;
  logic [StoreIndexW-1:0] store_index;
  logic [ByteW-1:0]       store_byte;
  logic                   frame_done;
  logic                   frame_rejected;
  logic [TotalW-1:0]      frame_total;
  logic                   link_enabled;
  logic                   collecting;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIndexW-1:0]   cfg_index = REG_SYNC_FIRST;
  logic [ByteW-1:0]       cfg_data = '0;

  // predictor state, mirrors the block after reset
  cfg_t             regs_now = '{SyncFirstReset, SyncSecondReset, EndFirstReset,
                                 EndSecondReset, LinkThresholdReset};
  logic [ByteW-1:0] prev_b = '0;
  logic [ByteW-1:0] prev2_b = '0;
  int unsigned      pos = 0;
  logic             in_frame = 1'b0;
  logic             hunting = 1'b0;
  logic [ByteW-1:0] link_cnt = '0;
  logic             link_on = 1'b0;
  logic [TotalW-1:0] accepted = '0;

  result_t     pending_results[$];
  logic        typed_on = 1'b0;
  result_t     typed_res = '0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  dir_row_t    dir_table [DirRows];

  header_trailer_frame_receiver_unit #(
    .FRAME_LEN(FrameLen)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .store_valid(store_valid),
    .store_index(store_index),
    .store_byte(store_byte),
    .frame_done(frame_done),
    .frame_rejected(frame_rejected),
    .frame_total(frame_total),
    .link_enabled(link_enabled),
    .collecting(collecting),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  function automatic result_t frame_rx_predict(input logic [ByteW-1:0] b);
    result_t r;
    r = '0;
    if (!link_on) begin
      link_cnt = link_cnt + 8'd1;
      if (link_cnt > regs_now.link_threshold) link_on = 1'b1;
    end
    // sync is only looked for while idle or hunting after a bad trailer
    if (!in_frame || hunting) begin
      if (prev_b == regs_now.sync_second && prev2_b == regs_now.sync_first) begin
        in_frame = 1'b1;
        pos = 0;
        hunting = 1'b0;
      end
    end
    if (in_frame && !hunting) begin
      r.store_valid = 1'b1;
      r.store_index = pos[StoreIndexW-1:0];
      r.store_byte = b;
      pos++;
      if (pos >= FrameLen) begin
        pos = FrameLen;
        if (b == regs_now.end_second && prev_b == regs_now.end_first) begin
          accepted = accepted + 16'd1;
          in_frame = 1'b0;
          r.frame_done = 1'b1;
        end else begin
          hunting = 1'b1;
          r.frame_rejected = 1'b1;
        end
      end
    end
    prev2_b = prev_b;
    prev_b = b;
    r.frame_total = accepted;
    r.link_enabled = link_on;
    r.collecting = in_frame && !hunting;
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    result_t want;
    result_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SYNC_FIRST:     regs_now.sync_first = cfg_data;
          REG_SYNC_SECOND:    regs_now.sync_second = cfg_data;
          REG_END_FIRST:      regs_now.end_first = cfg_data;
          REG_END_SECOND:     regs_now.end_second = cfg_data;
          REG_LINK_THRESHOLD: regs_now.link_threshold = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {store_valid, store_index, store_byte, frame_done, frame_rejected,
               frame_total, link_enabled, collecting};
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: unexpected, got %h", results_seen, got);
        end else begin
          want = pending_results.pop_front();
          if (got.store_valid !== want.store_valid || got.store_index !== want.store_index ||
              got.store_byte !== want.store_byte || got.frame_done !== want.frame_done ||
              got.frame_rejected !== want.frame_rejected ||
              got.frame_total !== want.frame_total ||
              got.link_enabled !== want.link_enabled ||
              got.collecting !== want.collecting) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $write("result %0d: exp st=%b idx=%0d byte=%h done=%b rej=%b tot=%0d",
                     results_seen, want.store_valid, want.store_index, want.store_byte,
                     want.frame_done, want.frame_rejected, want.frame_total);
              $write(" link=%b coll=%b | got st=%b idx=%0d byte=%h done=%b rej=%b",
                     want.link_enabled, want.collecting, got.store_valid,
                     got.store_index, got.store_byte, got.frame_done, got.frame_rejected);
              $display(" tot=%0d link=%b coll=%b", got.frame_total, got.link_enabled,
                       got.collecting);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        want = frame_rx_predict(rx_byte);
        if (typed_on) want = typed_res;
        pending_results.push_back(want);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte = b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // biased toward the pattern bytes so partial syncs and trailers show up
  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(7))
      0: return regs_now.sync_first;
      1: return regs_now.sync_second;
      2: return regs_now.end_first;
      3: return regs_now.end_second;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_burst();
    int unsigned kind;
    logic [ByteW-1:0] b;
    kind = $urandom_range(9);
    if (kind <= 6) begin
      // well-formed frame, trailer sometimes spoiled
      repeat ($urandom_range(3)) send_byte(8'($urandom));
      send_byte(regs_now.sync_first);
      send_byte(regs_now.sync_second);
      repeat (FrameLen - 2) send_byte(pick_byte());
      b = regs_now.end_first;
      if ($urandom_range(4) == 0) b = b ^ 8'($urandom_range(255, 1));
      send_byte(b);
      b = regs_now.end_second;
      if ($urandom_range(4) == 0) b = b ^ 8'($urandom_range(255, 1));
      send_byte(b);
    end else if (kind == 7) begin
      send_byte(regs_now.sync_first);
      send_byte(regs_now.sync_second);
      repeat ($urandom_range(10)) send_byte(pick_byte());
    end else begin
      repeat ($urandom_range(8, 1)) send_byte(pick_byte());
    end
  endtask

  initial begin : stimulus
    int unsigned i;
    int unsigned p;
    int unsigned phase_end;
    logic [ByteW-1:0] v;
    logic [ByteW-1:0] w;

    // default pattern FF FE, trailer 66 65, link after the 11th byte
    dir_table = '{
      {8'h00, 1'b1, 1'b0, 3'd0, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
      {8'hFF, Untyped},
      {8'hFE, Untyped},
      {8'h00, 1'b1, 1'b1, 3'd0, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0, 1'b1},
      {8'hFF, Untyped},
      {8'hFE, Untyped},  // sync inside a frame is ignored
      {8'h7F, Untyped},
      {8'h80, Untyped},
      {8'h01, Untyped},
      {8'h66, Untyped},
      {8'h65, 1'b1, 1'b1, 3'd7, 8'h65, 1'b1, 1'b0, 16'd1, 1'b1, 1'b0},
      {8'hFF, Untyped},
      {8'hFE, Untyped},
      {8'h11, Untyped},
      {8'h22, Untyped},
      {8'h33, Untyped},
      {8'h44, Untyped},
      {8'h55, Untyped},
      {8'hAA, Untyped},
      {8'h66, Untyped},
      {8'h64, 1'b1, 1'b1, 3'd7, 8'h64, 1'b0, 1'b1, 16'd1, 1'b1, 1'b0},
      {8'hFF, Untyped},
      {8'hFE, Untyped},
      {8'h65, Untyped}   // resync after the bad trailer
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < DirRows; i++) begin
      typed_on = dir_table[i].given;
      typed_res = dir_table[i].res;
      send_byte(dir_table[i].rx);
    end
    typed_on = 1'b0;

    for (p = 0; p < NumPhases; p++) begin
      in_valid = 1'b0;
      wait_drained();
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      case (p)
        0: ;
        1: begin
          write_reg(REG_SYNC_FIRST, 8'h00);
          write_reg(REG_SYNC_SECOND, 8'h00);
          write_reg(REG_END_FIRST, 8'hFF);
          write_reg(REG_END_SECOND, 8'hFF);
          write_reg(REG_LINK_THRESHOLD, 8'd0);
        end
        2: begin
          write_reg(REG_SYNC_FIRST, 8'hFF);
          write_reg(REG_SYNC_SECOND, 8'h00);
          write_reg(REG_END_FIRST, 8'h00);
          write_reg(REG_END_SECOND, 8'hFF);
          write_reg(REG_LINK_THRESHOLD, 8'd254);
          write_reg(RegUnused, 8'($urandom));
        end
        3: begin
          // trailer doubles as sync: a new frame can start right after a good one
          v = 8'($urandom);
          w = 8'($urandom);
          write_reg(REG_SYNC_FIRST, v);
          write_reg(REG_SYNC_SECOND, w);
          write_reg(REG_END_FIRST, v);
          write_reg(REG_END_SECOND, w);
          write_reg(REG_LINK_THRESHOLD, 8'($urandom_range(254)));
        end
        default: begin
          write_reg(REG_SYNC_FIRST, 8'($urandom));
          write_reg(REG_SYNC_SECOND, 8'($urandom));
          write_reg(REG_END_FIRST, 8'($urandom));
          write_reg(REG_END_SECOND, 8'($urandom));
          write_reg(REG_LINK_THRESHOLD, 8'($urandom_range(254)));
        end
      endcase
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) send_burst();
    end

    in_valid = 1'b0;
    wait_drained();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/htfr_pkg.sv
design/htfr_core.sv
design/header_trailer_frame_receiver_unit.sv
tb/header_trailer_frame_receiver_unit_tb.sv
